/* design/bsmr_pkg.sv */
// Shared constants, types and helper functions for the bounded stack block.
`default_nettype none
package bsmr_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH,
    OP_POP,
    OP_MIDDLE,
    OP_REVERSE
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_EMPTY,
    ST_TOO_FEW
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_WAIT,
    S_SWAP_RDA,
    S_SWAP_RDB,
    S_SWAP_WRA,
    S_SWAP_WRB
  } state_t;

  typedef enum logic [1:0] {
    RA_TOP,
    RA_MID,
    RA_LO,
    RA_HI
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_LO,
    WR_HI
  } wr_sel_t;

  typedef struct packed {
    logic       accept;
    logic       defer;
    logic       load_read;
    logic       swap_capture;
    logic       swap_step;
    raddr_sel_t raddr_sel;
    wr_sel_t    wr_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic few;
    logic pair_pending;
    logic out_free;
  } dp_status_t;

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] v);
    logic signed [63:0] x;
    x = 64'(signed'(v));
    return x[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] x;
    x = 64'(signed'(w));
    return x[VALUE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/bounded_stack_middle_reverse.sv */
// Top level of the bounded stack with middle read and bottom-half reversal.
// Results: push, reverse and every error give their result in the output register in the
// cycle after the transaction; pop and middle go through the registered RAM read first.
// Throughput: push one per cycle while the output is free; pop, middle and reverse hold off
// requests until done; reverse runs one read, read, write, write sequence per swapped pair.
// Reset: synchronous, clears the count, the controller and the output valid flag;
// the entry RAM is not cleared.
`default_nettype none
module bounded_stack_middle_reverse
  import bsmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // push_value[31:0]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // read_value[31:0], entry_count[36:32], zero[39:37]
  output logic [1:0]       m_tuser    // status[1:0]
);

  dp_cmd_t            cmd;
  dp_status_t         status;
  op_t                opcode;
  logic [VALUE_W-1:0] read_value;
  status_t            out_status;
  logic [COUNT_W-1:0] entry_count;

  assign opcode = op_t'(s_tuser);

  bsmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (opcode),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  bsmr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .push_value  (s_tdata),
    .out_ready   (m_tready),
    .status      (status),
    .out_valid   (m_tvalid),
    .read_value  (read_value),
    .out_status  (out_status),
    .entry_count (entry_count)
  );

  assign m_tdata = {3'b000, entry_count, read_value};
  assign m_tuser = out_status;

endmodule
`default_nettype wire

/* design/bsmr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bsmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_BITS-1:0]     waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [ADDR_BITS-1:0]     raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/bsmr_ctrl.sv */
// Controller state machine that sequences stack requests and pair swaps.
`default_nettype none
module bsmr_ctrl
  import bsmr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire op_t        opcode,
  input  wire dp_status_t status,
  output logic            in_ready,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_PUSH:    state_next = S_IDLE;
            OP_POP:     state_next = status.empty ? S_IDLE : S_READ_WAIT;
            OP_MIDDLE:  state_next = status.empty ? S_IDLE : S_READ_WAIT;
            OP_REVERSE: state_next = status.few ? S_IDLE : S_SWAP_RDA;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ_WAIT: state_next = S_IDLE;
      S_SWAP_RDA:  state_next = status.pair_pending ? S_SWAP_RDB : S_IDLE;
      S_SWAP_RDB:  state_next = S_SWAP_WRA;
      S_SWAP_WRA:  state_next = S_SWAP_WRB;
      S_SWAP_WRB:  state_next = S_SWAP_RDA;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.raddr_sel    = RA_TOP;
    cmd.wr_sel       = WR_NONE;
    cmd.accept       = accept;
    unique case (state)
      S_IDLE: begin
        cmd.raddr_sel = (opcode == OP_POP) ? RA_TOP : RA_MID;
        cmd.defer     = accept && ((opcode == OP_POP) || (opcode == OP_MIDDLE))
                        && !status.empty;
        if (accept && (opcode == OP_PUSH) && !status.full) begin
          cmd.wr_sel = WR_PUSH;
        end
      end
      S_READ_WAIT: cmd.load_read = 1'b1;
      S_SWAP_RDA:  cmd.raddr_sel = RA_LO;
      S_SWAP_RDB: begin
        cmd.raddr_sel    = RA_HI;
        cmd.swap_capture = 1'b1;
      end
      S_SWAP_WRA: cmd.wr_sel = WR_LO;
      S_SWAP_WRB: begin
        cmd.wr_sel    = WR_HI;
        cmd.swap_step = 1'b1;
      end
      default: cmd.raddr_sel = RA_TOP;
    endcase
  end

endmodule
`default_nettype wire

/* design/bsmr_datapath.sv */
// Datapath with the entry count, the entry RAM, swap pointers and result register.
`default_nettype none
module bsmr_datapath
  import bsmr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  input  wire op_t                opcode,
  input  wire logic [VALUE_W-1:0] push_value,
  input  wire logic               out_ready,
  output dp_status_t              status,
  output logic                    out_valid,
  output logic [VALUE_W-1:0]      read_value,
  output status_t                 out_status,
  output logic [COUNT_W-1:0]      entry_count
);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      count_m1;
  logic [CNT_W-1:0]      mid_index;
  logic [CNT_W-1:0]      half_m1;
  status_t               st;
  logic [ADDR_W-1:0]     lo;
  logic [ADDR_W-1:0]     hi;
  logic [DATA_WIDTH-1:0] temp;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [DATA_WIDTH-1:0] rdata;

  assign count_m1  = count - CNT_W'(1);
  assign mid_index = count_m1 >> 1;
  assign half_m1   = (count >> 1) - CNT_W'(1);

  assign status.empty        = (count == '0);
  assign status.full         = (count >= CNT_W'(DEPTH));
  assign status.few          = (count < CNT_W'(2));
  assign status.pair_pending = (lo < hi);
  assign status.out_free     = !out_valid || out_ready;

  always_comb begin
    st         = ST_OK;
    count_next = count;
    unique case (opcode)
      OP_PUSH: begin
        if (status.full) begin
          st = ST_OVERFLOW;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (status.empty) begin
          st = ST_EMPTY;
        end else begin
          count_next = count_m1;
        end
      end
      OP_MIDDLE: begin
        if (status.empty) begin
          st = ST_EMPTY;
        end
      end
      OP_REVERSE: begin
        if (status.few) begin
          st = ST_TOO_FEW;
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    unique case (cmd.raddr_sel)
      RA_TOP:  raddr = count_m1[ADDR_W-1:0];
      RA_MID:  raddr = mid_index[ADDR_W-1:0];
      RA_LO:   raddr = lo;
      RA_HI:   raddr = hi;
      default: raddr = lo;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = count[ADDR_W-1:0];
    wdata = to_word(push_value);
    unique case (cmd.wr_sel)
      WR_NONE: we = 1'b0;
      WR_PUSH: begin
        waddr = count[ADDR_W-1:0];
        wdata = to_word(push_value);
      end
      WR_LO: begin
        waddr = lo;
        wdata = rdata;
      end
      WR_HI: begin
        waddr = hi;
        wdata = temp;
      end
      default: we = 1'b0;
    endcase
  end

  bsmr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        count     <= count_next;
        out_valid <= !cmd.defer;
      end else if (cmd.load_read) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_value  <= '0;
      out_status  <= st;
      entry_count <= COUNT_W'(count_next);
      lo          <= '0;
      hi          <= half_m1[ADDR_W-1:0];
    end else begin
      if (cmd.load_read) begin
        read_value <= from_word(rdata);
      end
      if (cmd.swap_step) begin
        lo <= lo + ADDR_W'(1);
        hi <= hi - ADDR_W'(1);
      end
    end
    if (cmd.swap_capture) begin
      temp <= rdata;
    end
  end

endmodule
`default_nettype wire

/* verif/bsmr_reply_checker.sv */
// Checker for the bounded stack: tracks accepted requests, predicts replies and compares them.
`timescale 1ns / 100ps
module bsmr_reply_checker
  import bsmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // push_value[31:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // read_value[31:0], entry_count[36:32], zero[39:37]
  input  logic [1:0]  m_tuser,   // status[1:0]
  output int          mismatches,
  output int          outstanding,
  output int          replies_checked
);

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
  } stack_reply_t;

  logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
  int                    shadow_count = 0;
  stack_reply_t          replies_due [$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    replies_checked = 0;
  end

  function automatic stack_reply_t apply_request(op_t op, logic [VALUE_W-1:0] word);
    stack_reply_t          r;
    logic signed [63:0]    wide;
    logic [DATA_WIDTH-1:0] tmp;
    int                    half;
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          wide = $signed(word);
          shadow_mem[shadow_count] = wide[DATA_WIDTH-1:0];
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          wide = $signed(shadow_mem[shadow_count]);
          r.read_value = wide[VALUE_W-1:0];
        end
      end
      OP_MIDDLE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          wide = $signed(shadow_mem[(shadow_count - 1) / 2]);
          r.read_value = wide[VALUE_W-1:0];
        end
      end
      default: begin
        if (shadow_count < 2) begin
          r.status = ST_TOO_FEW;
        end else begin
          half = shadow_count / 2;
          for (int i = 0; i < half / 2; i++) begin
            tmp = shadow_mem[i];
            shadow_mem[i] = shadow_mem[half - 1 - i];
            shadow_mem[half - 1 - i] = tmp;
          end
        end
      end
    endcase
    r.entry_count = COUNT_W'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    if (rst) begin
      shadow_count = 0;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected reply: value %h status %0d count %0d", $realtime,
                     m_tdata[31:0], m_tuser, m_tdata[36:32]);
        end else begin
          want = replies_due.pop_front();
          replies_checked++;
          if (m_tdata[31:0] !== want.read_value || m_tuser !== want.status ||
              m_tdata[36:32] !== want.entry_count || m_tdata[39:37] !== 3'b000) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] reply mismatch: expected value %h status %s count %0d, got %h %0d %0d",
                       $realtime, want.read_value, want.status.name(), want.entry_count,
                       m_tdata[31:0], m_tuser, m_tdata[36:32]);
          end
        end
      end
      if (s_tvalid && s_tready)
        replies_due.push_back(apply_request(op_t'(s_tuser), s_tdata));
    end
    outstanding = replies_due.size();
  end

endmodule

/* verif/bounded_stack_middle_reverse_tb.sv */
// Testbench top for the bounded stack: clock, reset, request stimulus, reply stalls and verdict.
`timescale 1ns / 100ps
module bounded_stack_middle_reverse_tb;
  import bsmr_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // push_value[31:0]
  logic [1:0]  s_tuser  = '0;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // read_value[31:0], entry_count[36:32], zero[39:37]
  logic [1:0]  m_tuser;         // status[1:0]

  int mismatches;
  int outstanding;
  int replies_checked;
  int op_tally [4];
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int stall_left    = 0;

  bounded_stack_middle_reverse dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  bsmr_reply_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .mismatches, .outstanding, .replies_checked
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0)
      receiver_calm <= ~receiver_calm;
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!receiver_calm && $urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  task automatic send_request(op_t op, logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    op_tally[op]++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_bias;
    op_t op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Errors on an empty stack, then the single-entry cases.
    send_request(OP_POP, 32'h1234_5678);
    send_request(OP_MIDDLE, 32'hFFFF_FFFF);
    send_request(OP_REVERSE, 32'h0);
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_REVERSE, 32'h0);
    send_request(OP_MIDDLE, 32'h0);
    send_request(OP_POP, 32'h0);
    // Fill to capacity, overflow, then read and reverse a full stack.
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       send_request(OP_PUSH, 32'h7FFF_FFFF);
        1:       send_request(OP_PUSH, 32'h8000_0000);
        2:       send_request(OP_PUSH, 32'hFFFF_FFFF - i);
        default: send_request(OP_PUSH, i);
      endcase
    end
    send_request(OP_PUSH, 32'hDEAD_BEEF);
    send_request(OP_MIDDLE, 32'h0);
    send_request(OP_REVERSE, 32'h0);
    send_request(OP_POP, 32'h0);
    send_request(OP_MIDDLE, 32'h0);

    // Random phases that drift the fill level up and down.
    push_bias = 50;
    for (int n = 0; n < 400; n++) begin
      if (n % 25 == 0)
        case ($urandom_range(0, 2))
          0:       push_bias = 15;
          1:       push_bias = 45;
          default: push_bias = 75;
        endcase
      if ($urandom_range(0, 39) == 0)
        sender_calm = ~sender_calm;
      if ($urandom_range(0, 99) < push_bias)
        op = OP_PUSH;
      else
        op = op_t'($urandom_range(1, 3));
      send_request(op, pick_word());
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Requests sent: %0d push, %0d pop, %0d middle, %0d reverse.",
             op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_MIDDLE], op_tally[OP_REVERSE]);
    $display("Replies compared: %0d, mismatches: %0d.", replies_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
